// File: rtl/dfs_pkg.sv
// ----------------------------------------------------------------------------
// dfs_pkg
// Shared types and codes for the depth-first topological sort core.
// ----------------------------------------------------------------------------
`default_nettype none
package dfs_pkg;
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_CYCLE    = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;
  localparam logic [1:0] ST_BAD_END  = 2'd3;

  localparam logic [1:0] MK_NEW  = 2'd0;
  localparam logic [1:0] MK_PATH = 2'd1;
  localparam logic [1:0] MK_DONE = 2'd2;

  typedef struct packed {
    logic [5:0] from_node;
    logic [5:0] to_node;
    logic       edge_present;
    logic       final_item;
  } dfs_in_t;

  typedef struct packed {
    logic [5:0] order_node;
    logic [1:0] status;
    logic       run_end;
  } dfs_out_t;

  typedef enum logic [3:0] {
    S_LOAD, S_LINK, S_CLEAR, S_START, S_ROOT, S_TOP, S_EDGE, S_PROBE, S_EVAL,
    S_EMIT, S_FAIL
  } dfs_state_t;

  typedef struct packed {
    logic load;
    logic link;
    logic clear;
    logic start_read;
    logic start_next;
    logic push_start;
    logic read_top;
    logic read_edge;
    logic probe;
    logic eval;
    logic emit_fire;
    logic emit_init;
    logic fail_fire;
  } dfs_cmd_t;

  typedef struct packed {
    logic       err;
    logic       last_item;
    logic       start_done;
    logic       start_fresh;
    logic       stack_empty;
    logic       top_done_edge;
    logic       cycle_hit;
    logic       emit_last;
    logic       clear_done;
  } dfs_stat_t;
endpackage
`default_nettype wire

// File: rtl/dfs_topological_sort_core.sv
// ----------------------------------------------------------------------------
// dfs_topological_sort_core
// Depth-first topological sort of a streamed directed graph.
// ----------------------------------------------------------------------------
// Loading: an edge request is accepted in S_LOAD, then linked in S_LINK, where in_ready is low.
// Walk: a stored edge takes S_TOP, S_EDGE, S_PROBE, S_EVAL; finishing a node, S_TOP and S_EDGE;
// a scanned start node, S_START and S_ROOT; a walk root adds S_TOP on an empty stack, and
// S_START closes the scan. Emit: one result per cycle, unless out_ready stalls, from the
// datapath result register; one result on an error. Reset and every graph end run a clearing
// pass over all MAX_NODES per-node list and mark entries; no request is taken meanwhile.
`default_nettype none
module dfs_topological_sort_core
  import dfs_pkg::*;
#(
  parameter int MAX_NODES = 64,
  parameter int MAX_EDGES = 256
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     cfg_we,
  input  wire logic [6:0] cfg_data,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire dfs_in_t  in_data,
  output logic          out_valid,
  input  wire logic     out_ready,
  output dfs_out_t      out_data
);
  logic [6:0] node_count;
  dfs_cmd_t cmd;
  dfs_stat_t stat;
  logic in_fire, out_free;

  assign in_fire = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) node_count <= 7'd1;
    else if (cfg_we) node_count <= cfg_data;
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.emit_fire || cmd.fail_fire) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  dfs_ctrl u_ctrl (
    .clk, .rst, .in_fire, .out_free, .stat, .in_ready, .cmd
  );

  dfs_datapath #(.MAX_NODES(MAX_NODES), .MAX_EDGES(MAX_EDGES)) u_dp (
    .clk, .rst, .node_count, .in_data, .cmd, .stat, .res(out_data)
  );
endmodule
`default_nettype wire

// File: rtl/dfs_ctrl.sv
// ----------------------------------------------------------------------------
// dfs_ctrl
// Sequencer for load, per-graph clear, walk and result emission.
// ----------------------------------------------------------------------------
`default_nettype none
module dfs_ctrl
  import dfs_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_fire,
  input  wire logic      out_free,
  input  wire dfs_stat_t stat,
  output logic           in_ready,
  output dfs_cmd_t       cmd
);
  dfs_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_CLEAR;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_LOAD: begin
        if (in_fire) state_next = S_LINK;
      end
      S_LINK: begin
        if (stat.last_item) state_next = S_START;
        else state_next = S_LOAD;
      end
      S_CLEAR: begin
        if (stat.clear_done) state_next = S_LOAD;
      end
      S_START: begin
        if (stat.err) state_next = S_FAIL;
        else if (stat.start_done) state_next = S_EMIT;
        else state_next = S_ROOT;
      end
      S_ROOT: begin
        if (stat.start_fresh) state_next = S_TOP;
        else state_next = S_START;
      end
      S_TOP: begin
        if (stat.stack_empty) state_next = S_START;
        else state_next = S_EDGE;
      end
      S_EDGE: begin
        if (stat.top_done_edge) state_next = S_TOP;
        else state_next = S_PROBE;
      end
      S_PROBE: state_next = S_EVAL;
      S_EVAL: begin
        if (stat.cycle_hit) state_next = S_FAIL;
        else state_next = S_TOP;
      end
      S_EMIT: begin
        if (out_free && stat.emit_last) state_next = S_CLEAR;
      end
      S_FAIL: begin
        if (out_free) state_next = S_CLEAR;
      end
      default: state_next = S_CLEAR;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = (state == S_LOAD);
    case (state)
      S_LOAD: cmd.load = in_fire;
      S_LINK: cmd.link = 1'b1;
      S_CLEAR: cmd.clear = 1'b1;
      S_START: begin
        cmd.emit_init = 1'b1;
        cmd.start_read = !stat.err && !stat.start_done;
      end
      S_ROOT: begin
        cmd.start_next = 1'b1;
        cmd.push_start = stat.start_fresh;
      end
      S_TOP: cmd.read_top = 1'b1;
      S_EDGE: cmd.read_edge = 1'b1;
      S_PROBE: cmd.probe = 1'b1;
      S_EVAL: cmd.eval = 1'b1;
      S_EMIT: cmd.emit_fire = out_free;
      S_FAIL: cmd.fail_fire = out_free;
      default: ;
    endcase
  end

  a_no_load_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_LOAD) |-> !in_fire) else $error("input taken while busy");
  a_emit_to_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && out_free && stat.emit_last) |=> (state == S_CLEAR))
    else $error("run did not close");
  a_fail_out: assert property (@(posedge clk) disable iff (rst)
    (state == S_FAIL && out_free) |=> (state == S_CLEAR))
    else $error("fail result not closed");
endmodule
`default_nettype wire

// File: rtl/dfs_datapath.sv
// ----------------------------------------------------------------------------
// dfs_datapath
// Edge store, list heads and tails, visit marks, walk stack, finish list.
// ----------------------------------------------------------------------------
`default_nettype none
module dfs_datapath
  import dfs_pkg::*;
#(
  parameter int MAX_NODES = 64,
  parameter int MAX_EDGES = 256
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic [6:0] node_count,
  input  wire dfs_in_t  in_data,
  input  wire dfs_cmd_t cmd,
  output dfs_stat_t     stat,
  output dfs_out_t      res
);
  localparam int NW = $clog2(MAX_NODES);
  localparam int EW = $clog2(MAX_EDGES);
  localparam int PW = EW + 1;
  localparam logic [PW-1:0] NIL = PW'(MAX_EDGES);

  logic [5:0]    edge_target [MAX_EDGES];
  logic [PW-1:0] edge_link   [MAX_EDGES];
  logic [PW-1:0] list_head   [MAX_NODES];
  logic [PW-1:0] list_tail   [MAX_NODES];
  logic [1:0]    visit_mark  [MAX_NODES];
  logic [NW-1:0] stack_node  [MAX_NODES];
  logic [PW-1:0] stack_edge  [MAX_NODES];
  logic [5:0]    finish_list [MAX_NODES];

  logic [PW-1:0] edge_fill;
  logic [1:0]    error_latch;
  logic [NW:0]   clr_idx, start, depth, done, emit_idx;
  logic [6:0]    n_eff;
  logic [NW-1:0] top_node;
  logic [PW-1:0] top_edge;
  logic [5:0]    tgt;
  logic [PW-1:0] link_rd, tail_rd;
  dfs_in_t       ld_item;
  logic [1:0]    mark_rd;
  logic [PW-1:0] head_rd;

  always_comb begin
    if (node_count == 7'd0) n_eff = 7'd1;
    else if (node_count > 7'(MAX_NODES)) n_eff = 7'(MAX_NODES);
    else n_eff = node_count;
  end

  logic [NW-1:0] fn, fn_in, sn;
  logic bad_end, tgt_ok, link_ok;
  assign fn = ld_item.from_node[NW-1:0];
  assign fn_in = in_data.from_node[NW-1:0];
  assign sn = start[NW-1:0];
  assign bad_end = (7'(ld_item.from_node) >= n_eff) || (7'(ld_item.to_node) >= n_eff);
  assign link_ok = ld_item.edge_present && !bad_end && edge_fill < NIL;
  assign tgt_ok = 7'(tgt) < n_eff;

  // edge store; the slot at the fill point is unlinked until the link cycle
  always_ff @(posedge clk) begin
    if (cmd.load && edge_fill < NIL) begin
      edge_target[edge_fill[EW-1:0]] <= in_data.to_node;
      edge_link[edge_fill[EW-1:0]] <= NIL;
    end
    if (cmd.link && link_ok && tail_rd != NIL)
      edge_link[tail_rd[EW-1:0]] <= edge_fill;
    if (cmd.read_edge && top_edge != NIL) begin
      tgt <= edge_target[top_edge[EW-1:0]];
      link_rd <= edge_link[top_edge[EW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      edge_fill <= '0; error_latch <= '0; clr_idx <= '0;
      start <= '0; depth <= '0; done <= '0; emit_idx <= '0;
    end else begin
      if (cmd.clear) begin
        list_head[clr_idx[NW-1:0]] <= NIL;
        list_tail[clr_idx[NW-1:0]] <= NIL;
        visit_mark[clr_idx[NW-1:0]] <= MK_NEW;
        clr_idx <= stat.clear_done ? '0 : clr_idx + 1'b1;
        edge_fill <= '0; error_latch <= '0;
        start <= '0; depth <= '0; done <= '0;
      end
      if (cmd.load) begin
        ld_item <= in_data;
        tail_rd <= list_tail[fn_in];
      end
      if (cmd.link && ld_item.edge_present) begin
        if (bad_end) begin
          if (error_latch == ST_OK) error_latch <= ST_BAD_END;
        end else if (edge_fill >= NIL) begin
          if (error_latch == ST_OK) error_latch <= ST_OVERFLOW;
        end else begin
          if (tail_rd == NIL) list_head[fn] <= edge_fill;
          list_tail[fn] <= edge_fill;
          edge_fill <= edge_fill + 1'b1;
        end
      end
      if (cmd.emit_init) emit_idx <= '0;
      if (cmd.start_read) begin
        mark_rd <= visit_mark[sn];
        head_rd <= list_head[sn];
      end
      if (cmd.start_next) begin
        start <= start + 1'b1;
        if (cmd.push_start) begin
          visit_mark[sn] <= MK_PATH;
          stack_node[0] <= sn;
          stack_edge[0] <= head_rd;
          depth <= (NW+1)'(1);
        end
      end
      if (cmd.read_top && depth != 0) begin
        top_node <= stack_node[NW'(depth - 1'b1)];
        top_edge <= stack_edge[NW'(depth - 1'b1)];
      end
      if (cmd.read_edge && top_edge == NIL) begin
        visit_mark[top_node] <= MK_DONE;
        finish_list[done[NW-1:0]] <= 6'(top_node);
        done <= done + 1'b1;
        depth <= depth - 1'b1;
      end
      if (cmd.probe) begin
        mark_rd <= visit_mark[tgt[NW-1:0]];
        head_rd <= list_head[tgt[NW-1:0]];
        stack_edge[NW'(depth - 1'b1)] <= link_rd;
      end
      if (cmd.eval) begin
        if (tgt_ok && mark_rd == MK_NEW && depth < (NW+1)'(MAX_NODES)) begin
          visit_mark[tgt[NW-1:0]] <= MK_PATH;
          stack_node[depth[NW-1:0]] <= tgt[NW-1:0];
          stack_edge[depth[NW-1:0]] <= head_rd;
          depth <= depth + 1'b1;
        end
      end
      if (cmd.emit_fire) emit_idx <= emit_idx + 1'b1;
    end
  end

  logic [NW:0] n_w;
  assign n_w = (NW+1)'(n_eff);

  always_comb begin
    stat.err = (error_latch != ST_OK);
    stat.last_item = ld_item.final_item;
    stat.start_done = (start >= n_w);
    stat.start_fresh = (mark_rd == MK_NEW);
    stat.stack_empty = (depth == 0);
    stat.top_done_edge = (top_edge == NIL);
    stat.cycle_hit = tgt_ok && (mark_rd == MK_PATH);
    stat.emit_last = (emit_idx + 1'b1 == n_w);
    stat.clear_done = (clr_idx == (NW+1)'(MAX_NODES - 1));
  end

  logic [NW:0] ridx;
  assign ridx = n_w - 1'b1 - emit_idx;

  // result register
  always_ff @(posedge clk) begin
    if (cmd.emit_fire) begin
      res.order_node <= finish_list[ridx[NW-1:0]];
      res.status <= ST_OK;
      res.run_end <= stat.emit_last;
    end else if (cmd.fail_fire) begin
      res.order_node <= '0;
      res.status <= stat.err ? error_latch : ST_CYCLE;
      res.run_end <= 1'b1;
    end
  end

  a_fill_max: assert property (@(posedge clk) disable iff (rst)
    edge_fill <= NIL) else $error("edge fill past capacity");
  a_depth_max: assert property (@(posedge clk) disable iff (rst)
    depth <= (NW+1)'(MAX_NODES)) else $error("stack overflow");
  a_done_max: assert property (@(posedge clk) disable iff (rst)
    done <= (NW+1)'(MAX_NODES)) else $error("finish list overflow");
endmodule
`default_nettype wire

// File: tb/sv/dfs_topological_sort_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dfs_topological_sort_core_test
// Streams directed graphs into the sort core, predicts each topological
// order, cycle result or error code, and compares every result field.
// ----------------------------------------------------------------------------
module dfs_topological_sort_core_test;
  import dfs_pkg::*;

  localparam int NODE_LIMIT = 64;
  localparam int EDGE_LIMIT = 256;
  localparam int NIL = EDGE_LIMIT;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     cfg_we = 1'b0;
  logic [6:0] cfg_data = 7'd1;
  logic     in_valid = 1'b0;
  logic     in_ready;
  dfs_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  dfs_out_t out_data;

  always #6 clk = ~clk;

  dfs_topological_sort_core dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  // predictor state
  logic [6:0] node_reg;
  logic [5:0] tgt_mem [EDGE_LIMIT];
  int         nxt_mem [EDGE_LIMIT];
  int         head_q [NODE_LIMIT];
  int         tail_q [NODE_LIMIT];
  int         edges_held;
  logic [1:0] err_code;
  logic [1:0] mark [NODE_LIMIT];
  logic [5:0] done_nodes [NODE_LIMIT];

  dfs_out_t order_q[$];
  int       mismatches = 0;
  bit       idle_on = 1'b1;

  function automatic int active_nodes();
    int k;
    k = node_reg;
    if (k < 1) k = 1;
    if (k > NODE_LIMIT) k = NODE_LIMIT;
    return k;
  endfunction

  function automatic void graph_clear();
    for (int i = 0; i < NODE_LIMIT; i++) begin
      head_q[i] = NIL;
      tail_q[i] = NIL;
      mark[i] = MK_NEW;
    end
    edges_held = 0;
    err_code = ST_OK;
  endfunction

  function automatic bit walk_has_cycle(int n);
    int snode [NODE_LIMIT];
    int sedge [NODE_LIMIT];
    int depth, cnt, top, nd, e, t;
    cnt = 0;
    for (int s = 0; s < n; s++) begin
      if (mark[s] != MK_NEW) continue;
      mark[s] = MK_PATH;
      snode[0] = s;
      sedge[0] = head_q[s];
      depth = 1;
      while (depth > 0) begin
        top = depth - 1;
        nd = snode[top];
        e = sedge[top];
        if (e >= NIL) begin
          mark[nd] = MK_DONE;
          if (cnt < NODE_LIMIT) begin
            done_nodes[cnt] = nd[5:0];
            cnt++;
          end
          depth--;
          continue;
        end
        t = tgt_mem[e];
        sedge[top] = nxt_mem[e];
        if (t >= n) continue;
        if (mark[t] == MK_PATH) return 1'b1;
        if (mark[t] == MK_NEW && depth < NODE_LIMIT) begin
          mark[t] = MK_PATH;
          snode[depth] = t;
          sedge[depth] = head_q[t];
          depth++;
        end
      end
    end
    return 1'b0;
  endfunction

  function automatic void predict_request(dfs_in_t r);
    int n;
    dfs_out_t o;
    n = active_nodes();
    if (r.edge_present) begin
      if (r.from_node >= n || r.to_node >= n) begin
        if (err_code == ST_OK) err_code = ST_BAD_END;
      end else if (edges_held >= EDGE_LIMIT) begin
        if (err_code == ST_OK) err_code = ST_OVERFLOW;
      end else begin
        tgt_mem[edges_held] = r.to_node;
        nxt_mem[edges_held] = NIL;
        if (tail_q[r.from_node] >= NIL) head_q[r.from_node] = edges_held;
        else nxt_mem[tail_q[r.from_node]] = edges_held;
        tail_q[r.from_node] = edges_held;
        edges_held++;
      end
    end
    if (!r.final_item) return;
    if (err_code != ST_OK) begin
      o = '{order_node: 6'd0, status: err_code, run_end: 1'b1};
      order_q.insert(order_q.size(), o);
    end else if (walk_has_cycle(n)) begin
      o = '{order_node: 6'd0, status: ST_CYCLE, run_end: 1'b1};
      order_q.insert(order_q.size(), o);
    end else begin
      for (int i = 0; i < n; i++) begin
        o = '{order_node: done_nodes[n - 1 - i], status: ST_OK, run_end: (i + 1 == n)};
        order_q.insert(order_q.size(), o);
      end
    end
    graph_clear();
  endfunction

  task automatic send_request(logic [5:0] f, logic [5:0] t, bit e, bit last);
    dfs_in_t r;
    r = '{from_node: f, to_node: t, edge_present: e, final_item: last};
    while (idle_on && $urandom_range(99) < 13) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_data <= r;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_request(r);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (order_q.size() != 0) @(negedge clk);
    repeat (400) @(negedge clk);
  endtask

  task automatic set_nodes(logic [6:0] v);
    drain();
    cfg_data <= v;
    cfg_we <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
    node_reg = v;
  endtask

  always @(negedge clk) out_ready <= !(idle_on && $urandom_range(99) < 13);

  always @(posedge clk) begin
    dfs_out_t exp_o;
    if (!rst && out_valid && out_ready) begin
      if (order_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", out_data);
      end else begin
        exp_o = order_q.pop_front();
        if (out_data.order_node !== exp_o.order_node || out_data.status !== exp_o.status ||
            out_data.run_end !== exp_o.run_end) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p got %p", exp_o, out_data);
        end
      end
    end
  end

  task automatic test_directed();
    set_nodes(7'd1);
    send_request(6'd0, 6'd0, 1'b0, 1'b1);
    set_nodes(7'd4);
    send_request(6'd0, 6'd1, 1'b1, 1'b0);
    send_request(6'd1, 6'd2, 1'b1, 1'b0);
    send_request(6'd3, 6'd2, 1'b1, 1'b0);
    send_request(6'd0, 6'd3, 1'b1, 1'b1);
    send_request(6'd0, 6'd1, 1'b1, 1'b0);
    send_request(6'd1, 6'd0, 1'b1, 1'b1);
    send_request(6'd2, 6'd2, 1'b1, 1'b1);
    send_request(6'd63, 6'd0, 1'b1, 1'b0);
    send_request(6'd0, 6'd1, 1'b1, 1'b1);
    send_request(6'd0, 6'd63, 1'b1, 1'b1);
    set_nodes(7'd64);
    send_request(6'd63, 6'd0, 1'b1, 1'b0);
    send_request(6'd0, 6'd63, 1'b1, 1'b1);
    send_request(6'd63, 6'd62, 1'b1, 1'b1);
    set_nodes(7'd0);
    send_request(6'd0, 6'd0, 1'b0, 1'b1);
    set_nodes(7'd127);
    send_request(6'd5, 6'd63, 1'b1, 1'b1);
    set_nodes(7'd8);
    send_request(6'd7, 6'd6, 1'b1, 1'b0);
    send_request(6'd2, 6'd7, 1'b1, 1'b0);
    set_nodes(7'd5);
    send_request(6'd1, 6'd2, 1'b1, 1'b1);
  endtask

  task automatic test_overflow();
    set_nodes(7'd64);
    for (int i = 0; i < 258; i++)
      send_request(6'($urandom_range(63)), 6'($urandom_range(63)), 1'b1, i == 257);
  endtask

  task automatic test_random();
    int n, len;
    bit dag;
    for (int g = 0; g < 25; g++) begin
      if (g == 10) idle_on = 1'b0;
      if (g == 20) idle_on = 1'b1;
      n = (g % 9 == 8) ? 64 : $urandom_range(2, 12);
      set_nodes(n[6:0]);
      len = $urandom_range(1, 10);
      dag = $urandom_range(3) != 0;
      for (int i = 0; i < len; i++) begin
        int a, b;
        a = $urandom_range(n - 1);
        b = $urandom_range(n - 1);
        if (dag && a > b) begin int t; t = a; a = b; b = t; end
        if (dag && a == b) b = (a + 1 < n) ? a + 1 : a;
        if (dag && a == b) a = 0;
        if (a == b && dag) send_request(6'd0, 6'd0, 1'b0, i == len - 1);
        else if ($urandom_range(30) == 0)
          send_request(6'($urandom_range(63)), 6'($urandom_range(63)), 1'b1, i == len - 1);
        else send_request(a[5:0], b[5:0], $urandom_range(15) != 0, i == len - 1);
      end
    end
  endtask

  initial begin
    graph_clear();
    node_reg = 7'd1;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_overflow();
    test_random();
    drain();
    if (mismatches == 0 && order_q.size() == 0) begin
      $display("[dfs_topological_sort_core] OK");
    end else begin
      $display("[dfs_topological_sort_core] ERROR");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("[dfs_topological_sort_core] ERROR");
    $finish;
  end
endmodule

// File: filelist.f
rtl/dfs_pkg.sv
rtl/dfs_ctrl.sv
rtl/dfs_datapath.sv
rtl/dfs_topological_sort_core.sv
tb/sv/dfs_topological_sort_core_test.sv
